>>> design/pdi_pkg.sv
// pdi_pkg: shared constants, types and helpers for the particle update pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pdi_pkg;

  localparam logic [12:0] DT_MAX   = 13'd6554;
  localparam logic [30:0] MASS_MIN = 31'd66;
  localparam logic [48:0] TERM_CAP = 49'h1_0000_0000_0000;

  localparam logic [2:0] CFG_GRAV_X = 3'd0;
  localparam logic [2:0] CFG_GRAV_Y = 3'd1;
  localparam logic [2:0] CFG_GRAV_Z = 3'd2;
  localparam logic [2:0] CFG_MASS   = 3'd3;
  localparam logic [2:0] CFG_KILL_EN = 3'd4;
  localparam logic [2:0] CFG_KILL_SPD = 3'd5;

  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = 32;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] life;
    logic [30:0] drag;
    logic [12:0] dt;
    logic        armed;
    logic        last;
  } pass_t;

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    logic [31:0] r;
    if (v > 33'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -33'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/pdi_delay.sv
// pdi_delay: enable-gated register line of fixed depth
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module pdi_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);
  logic [W-1:0] tap_r [0:D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < D; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[D-1];
endmodule
`default_nettype wire

>>> design/pdi_udiv.sv
// pdi_udiv: pipelined restoring divider, one quotient bit per stage
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module pdi_udiv #(
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] rem0,
  input  wire logic [QW-1:0] sh0,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quo
);
  logic [DW-1:0] rem_r [1:QW];
  logic [QW-1:0] sh_r  [1:QW];
  logic [DW-1:0] den_r [1:QW];
  logic [DW-1:0] cur_rem [0:QW-1];
  logic [QW-1:0] cur_sh  [0:QW-1];
  logic [DW-1:0] cur_den [0:QW-1];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    logic [QW:0] sh_ext;
    if (j == 0) begin : g_first
      assign cur_rem[j] = rem0;
      assign cur_sh[j]  = sh0;
      assign cur_den[j] = den;
    end else begin : g_next
      assign cur_rem[j] = rem_r[j];
      assign cur_sh[j]  = sh_r[j];
      assign cur_den[j] = den_r[j];
    end
    assign trial  = {cur_rem[j], cur_sh[j][QW-1]};
    assign ge     = trial >= {1'b0, cur_den[j]};
    assign diff   = trial - {1'b0, cur_den[j]};
    assign sh_ext = {cur_sh[j], ge};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        sh_r[j+1]  <= sh_ext[QW-1:0];
        den_r[j+1] <= cur_den[j];
      end
    end
  end

  assign quo = sh_r[QW];
endmodule
`default_nettype wire

>>> design/pdi_isqrt.sv
// pdi_isqrt: pipelined integer square root, one root bit per stage
// depends on pdi_pkg
`timescale 1ns / 1ps
`default_nettype none
module pdi_isqrt
  import pdi_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [SQ_IN_W-1:0]  n,
  output logic      [SQ_OUT_W-1:0] root
);
  localparam int S = SQ_OUT_W;

  logic [S+1:0]       rem_r  [1:S];
  logic [S-1:0]       root_r [1:S];
  logic [SQ_IN_W-1:0] sh_r   [1:S];
  logic [S+1:0]       cur_rem  [0:S-1];
  logic [S-1:0]       cur_root [0:S-1];
  logic [SQ_IN_W-1:0] cur_sh   [0:S-1];

  for (genvar j = 0; j < S; j++) begin : g_stage
    logic [S+3:0] acc;
    logic [S+3:0] trial;
    logic [S+3:0] diff;
    logic         ge;
    if (j == 0) begin : g_first
      assign cur_rem[j]  = '0;
      assign cur_root[j] = '0;
      assign cur_sh[j]   = n;
    end else begin : g_next
      assign cur_rem[j]  = rem_r[j];
      assign cur_root[j] = root_r[j];
      assign cur_sh[j]   = sh_r[j];
    end
    assign acc   = {cur_rem[j], cur_sh[j][SQ_IN_W-1 -: 2]};
    assign trial = {2'b00, cur_root[j], 2'b01};
    assign ge    = acc >= trial;
    assign diff  = acc - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= ge ? diff[S+1:0] : acc[S+1:0];
        root_r[j+1] <= {cur_root[j][S-2:0], ge};
        sh_r[j+1]   <= {cur_sh[j][SQ_IN_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[S];
endmodule
`default_nettype wire

>>> design/particle_drag_integrate_step_core.sv
// particle_drag_integrate_step_core: pipelined particle update with implicit drag
// depends on pdi_pkg, pdi_delay, pdi_udiv, pdi_isqrt
//
// channel  dir  handshake          beat
// in_      in   in_valid/in_stall  one particle and time step
// out_     out  out_valid/out_stall one updated particle
// cfg_     in   cfg_we             one register write
//
// one particle per cycle while the output is not stalled
// the path runs through the 44-stage k divider, then the 32-stage velocity divider
// the whole pipeline holds while a beat waits at the output; in_stall follows it
// reset clears valid bits and returns configuration registers to their defaults only
`timescale 1ns / 1ps
`default_nettype none
module particle_drag_integrate_step_core
  import pdi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_step_time,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_vel_x,
  input  wire logic [31:0] in_vel_y,
  input  wire logic [31:0] in_vel_z,
  input  wire logic [30:0] in_drag_coeff,
  input  wire logic [31:0] in_life_left,
  input  wire logic        in_armed_in,
  input  wire logic        in_last_particle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_new_pos_x,
  output logic [31:0]      out_new_pos_y,
  output logic [31:0]      out_new_pos_z,
  output logic [31:0]      out_new_vel_x,
  output logic [31:0]      out_new_vel_y,
  output logic [31:0]      out_new_vel_z,
  output logic [31:0]      out_new_life,
  output logic             out_armed_out,
  output logic             out_alive,
  output logic [30:0]      out_drag_out,
  output logic             out_last_out
);
  localparam int NST = 81;

  logic [31:0] grav_r [0:2];
  logic [30:0] mass_r;
  logic        kill_en_r;
  logic [31:0] kill_spd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r[0]  <= '0;
      grav_r[1]  <= '0;
      grav_r[2]  <= '0;
      mass_r     <= 31'd65536;
      kill_en_r  <= 1'b0;
      kill_spd_r <= 32'hffff_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAV_X:   grav_r[0]  <= cfg_wdata;
        CFG_GRAV_Y:   grav_r[1]  <= cfg_wdata;
        CFG_GRAV_Z:   grav_r[2]  <= cfg_wdata;
        CFG_MASS:     mass_r     <= cfg_wdata[30:0];
        CFG_KILL_EN:  kill_en_r  <= cfg_wdata[0];
        CFG_KILL_SPD: kill_spd_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [NST:1] valid_r;
  logic         en;

  assign en       = !(valid_r[NST] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NST-1:1], in_valid};
    end
  end

  // stage 1: clamp, gravity and drag products
  logic [12:0] dt_c;
  logic [31:0] vin [0:2];
  always_comb begin
    if (in_step_time[31]) begin
      dt_c = '0;
    end else if (in_step_time > {19'b0, DT_MAX}) begin
      dt_c = DT_MAX;
    end else begin
      dt_c = in_step_time[12:0];
    end
  end
  assign vin[0] = in_vel_x;
  assign vin[1] = in_vel_y;
  assign vin[2] = in_vel_z;

  logic signed [45:0] gp_s1 [0:2];
  logic [31:0]        vel_s1 [0:2];
  logic [43:0]        kd_s1;
  logic [30:0]        mass_s1;
  pass_t              pass_s1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        gp_s1[a]  <= $signed(grav_r[a]) * $signed({1'b0, dt_c});
        vel_s1[a] <= vin[a];
      end
      kd_s1   <= 44'(in_drag_coeff) * 44'(dt_c);
      mass_s1 <= (mass_r < MASS_MIN) ? MASS_MIN : mass_r;
      pass_s1 <= '{pos_x: in_pos_x, pos_y: in_pos_y, pos_z: in_pos_z,
                   life: in_life_left, drag: in_drag_coeff, dt: dt_c,
                   armed: in_armed_in, last: in_last_particle};
    end
  end

  // stage 2: velocity plus gravity term
  logic [31:0] v1_s2 [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        v1_s2[a] <= sat33($signed({vel_s1[a][31], vel_s1[a]}) +
                          $signed(33'(gp_s1[a] >>> 16)));
      end
    end
  end

  // stage 3: magnitudes and squares
  logic [31:0] mag_s3 [0:2];
  logic [2:0]  neg_s3;
  logic [63:0] sq_s3 [0:2];
  logic [31:0] mag_c [0:2];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag_c[a] = v1_s2[a][31] ? (~v1_s2[a] + 32'd1) : v1_s2[a];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        mag_s3[a] <= mag_c[a];
        neg_s3[a] <= v1_s2[a][31];
        sq_s3[a]  <= 64'(mag_c[a]) * 64'(mag_c[a]);
      end
    end
  end

  // stage 4: sum of squares
  logic [63:0] sumsq_s4;
  always_ff @(posedge clk) begin
    if (en) begin
      sumsq_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
    end
  end

  logic [31:0] speed_s36;
  logic [31:0] speed_s45;
  logic [43:0] k_s45;

  pdi_isqrt u_isqrt (.clk(clk), .en(en), .n(sumsq_s4), .root(speed_s36));

  pdi_delay #(.W(32), .D(9)) u_speed_dly (
    .clk(clk), .en(en), .din(speed_s36), .dout(speed_s45)
  );

  pdi_udiv #(.DW(31), .QW(44)) u_kdiv (
    .clk(clk), .en(en), .rem0('0), .sh0(kd_s1), .den(mass_s1), .quo(k_s45)
  );

  // stages 46 and 47: drag term, split product, denominator
  logic [50:0] plo_s46;
  logic [50:0] phi_s46;
  logic [48:0] denom_s47;
  logic [69:0] prod_c;
  logic [53:0] term_c;
  always_ff @(posedge clk) begin
    if (en) begin
      plo_s46 <= 51'(k_s45[18:0]) * 51'(speed_s45);
      phi_s46 <= 51'(k_s45[37:19]) * 51'(speed_s45);
    end
  end
  assign prod_c = {phi_s46, 19'b0} + 70'(plo_s46);
  assign term_c = prod_c[69:16];
  always_ff @(posedge clk) begin
    if (en) begin
      denom_s47 <= 49'd65536 +
                   ((term_c > 54'(TERM_CAP)) ? TERM_CAP : term_c[48:0]);
    end
  end

  logic [95:0] mag_s47;
  logic [2:0]  neg_s79;
  pass_t       pass_s79;
  logic [31:0] q_s79 [0:2];

  pdi_delay #(.W(96), .D(44)) u_mag_dly (
    .clk(clk), .en(en), .din({mag_s3[0], mag_s3[1], mag_s3[2]}), .dout(mag_s47)
  );
  pdi_delay #(.W(3), .D(76)) u_neg_dly (
    .clk(clk), .en(en), .din(neg_s3), .dout(neg_s79)
  );
  pdi_delay #(.W($bits(pass_t)), .D(78)) u_pass_dly (
    .clk(clk), .en(en), .din(pass_s1), .dout(pass_s79)
  );

  for (genvar a = 0; a < 3; a++) begin : g_vdiv
    logic [31:0] m;
    assign m = mag_s47[95-32*a -: 32];
    pdi_udiv #(.DW(49), .QW(32)) u_vdiv (
      .clk(clk), .en(en), .rem0({33'b0, m[31:16]}), .sh0({m[15:0], 16'b0}),
      .den(denom_s47), .quo(q_s79[a])
    );
  end

  // stage 80: signed velocity, position step, new speed squares
  logic [31:0]        v2_s80 [0:2];
  logic signed [45:0] pm_s80 [0:2];
  logic [63:0]        sq2_s80 [0:2];
  logic [61:0]        ss_s80;
  pass_t              pass_s80;
  logic [31:0]        v2_c [0:2];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      v2_c[a] = neg_s79[a] ? (~q_s79[a] + 32'd1) : q_s79[a];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        v2_s80[a]  <= v2_c[a];
        pm_s80[a]  <= $signed(v2_c[a]) * $signed({1'b0, pass_s79.dt});
        sq2_s80[a] <= 64'(q_s79[a]) * 64'(q_s79[a]);
      end
      ss_s80   <= 62'(kill_spd_r[30:0]) * 62'(kill_spd_r[30:0]);
      pass_s80 <= pass_s79;
    end
  end

  // stage 81: output register
  logic [31:0] pos_c [0:2];
  logic [63:0] sum2_c;
  logic        fast_c;
  logic        kill_c;
  logic [31:0] life_c;
  assign pos_c[0] = pass_s80.pos_x;
  assign pos_c[1] = pass_s80.pos_y;
  assign pos_c[2] = pass_s80.pos_z;
  assign sum2_c   = sq2_s80[0] + sq2_s80[1] + sq2_s80[2];
  assign fast_c   = kill_spd_r[31] || (sum2_c > 64'(ss_s80));
  assign kill_c   = kill_en_r && pass_s80.armed && !fast_c;
  assign life_c   = kill_c ? 32'd0 :
                    sat33($signed({pass_s80.life[31], pass_s80.life}) -
                          $signed({20'b0, pass_s80.dt}));

  logic [31:0] npos_r [0:2];
  logic [31:0] nvel_r [0:2];
  logic [31:0] life_r;
  logic        armed_r;
  logic [30:0] drag_r;
  logic        last_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        npos_r[a] <= sat33($signed({pos_c[a][31], pos_c[a]}) +
                           $signed(33'(pm_s80[a] >>> 16)));
        nvel_r[a] <= v2_s80[a];
      end
      life_r  <= life_c;
      armed_r <= pass_s80.armed || (fast_c && kill_en_r);
      drag_r  <= pass_s80.drag;
      last_r  <= pass_s80.last;
    end
  end

  assign out_valid     = valid_r[NST];
  assign out_new_pos_x = npos_r[0];
  assign out_new_pos_y = npos_r[1];
  assign out_new_pos_z = npos_r[2];
  assign out_new_vel_x = nvel_r[0];
  assign out_new_vel_y = nvel_r[1];
  assign out_new_vel_z = nvel_r[2];
  assign out_new_life  = life_r;
  assign out_armed_out = armed_r;
  assign out_alive     = !life_r[31] && (life_r != 32'd0);
  assign out_drag_out  = drag_r;
  assign out_last_out  = last_r;

`ifndef SYNTH
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[40] && in_stall) |=> valid_r[40])
    else $error("mid-pipeline beat dropped under stall");
  a_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alive == ($signed(out_new_life) > 0)))
    else $error("alive flag disagrees with lifetime");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_new_pos_x)))
    else $error("stalled result changed");
`endif
endmodule
`default_nettype wire
